### rtl/v3alu_pkg.sv
`default_nettype none

package v3alu_pkg;

  localparam int unsigned FRAC_BITS = 16;

  // pipeline section depths
  localparam int unsigned N_NORM  = 5;              // pair-wise leading zero shift
  localparam int unsigned N_SQRT  = 32;             // one root bit per stage
  localparam int unsigned QW      = FRAC_BITS + 1;  // normalised quotient width
  localparam int unsigned N_DIV   = QW;             // one quotient bit per stage
  localparam int unsigned LATENCY = 4 + N_NORM + N_SQRT + N_DIV + 1;

  localparam logic [31:0] MAX32 = 32'h7fff_ffff;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_SCALE = 3'd2,
    CMD_DOT   = 3'd3,
    CMD_CROSS = 3'd4,
    CMD_MAG   = 3'd5,
    CMD_NORM  = 3'd6
  } cmd_e;

  // side data carried alongside the long sqrt/divide sections
  typedef struct packed {
    cmd_e             cmd;
    logic [2:0][31:0] r;
    logic [31:0]      sc;
    logic             zl;
    logic             ovf;
    logic [2:0]       neg;
    logic [2:0][31:0] x;    // |a_i|, shifted left with the normalising shift
  } item_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t o;
    o.ovf = 1'b0;
    o.val = v[31:0];
    if (v > 66'sd2147483647) begin
      o.ovf = 1'b1;
      o.val = MAX32;
    end else if (v < -66'sd2147483648) begin
      o.ovf = 1'b1;
      o.val = ~MAX32;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

### rtl/vector3_alu.sv
`default_nettype none

// Three-component vector ALU on signed fixed point (v3alu_pkg::FRAC_BITS fraction bits).
// Fully pipelined: one word is taken every clock and busy_o never rises. Each
// result reaches done_o through the input register, the product, sum and saturate
// stages, the normalising shift, square root, divider and output register, in issue
// order, for every command alike; the depth is set by the 32-stage square root and
// the bit-per-stage divider that normalise uses. The receiver cannot hold results off,
// so it must take done_o words as they come.
module vector3_alu (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [31:0] a_x_i,
  input  wire logic [31:0] a_y_i,
  input  wire logic [31:0] a_z_i,
  input  wire logic [31:0] b_x_i,
  input  wire logic [31:0] b_y_i,
  input  wire logic [31:0] b_z_i,
  input  wire logic [31:0] scale_factor_i,
  output logic             done_o,
  output logic [31:0]      r_x_o,
  output logic [31:0]      r_y_o,
  output logic [31:0]      r_z_o,
  output logic [31:0]      scalar_out_o,
  output logic             zero_length_o,
  output logic             overflow_o
);
  import v3alu_pkg::*;

  typedef struct packed {
    item_t       it;
    logic [63:0] t;
  } nrm_t;

  typedef struct packed {
    item_t       it;
    logic [63:0] n;
    logic [63:0] res;
  } sqr_t;

  typedef struct packed {
    item_t               it;
    logic [31:0]         m;
    logic [2:0][31:0]    rem;
    logic [2:0][QW-1:0]  q;
  } div_t;

  assign busy_o = 1'b0;

  // ---------------- stage 1: input register
  logic                    s1_v_q;
  cmd_e                    s1_cmd_q;
  logic signed [2:0][31:0] s1_a_q, s1_b_q;
  logic signed [31:0]      s1_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else         s1_v_q <= start_i;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s1_cmd_q <= cmd_e'(command_i);
      s1_a_q   <= {a_z_i, a_y_i, a_x_i};
      s1_b_q   <= {b_z_i, b_y_i, b_x_i};
      s1_s_q   <= scale_factor_i;
    end
  end

  // ---------------- stage 2: products, add/sub, magnitudes of a
  logic signed [31:0] opa [6];
  logic signed [31:0] opb [6];
  logic signed [63:0] s2_p_q [6];
  logic               s2_v_q;
  item_t              s2_it_d, s2_it_q;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      opa[i] = s1_a_q[i % 3];
      opb[i] = s1_a_q[i % 3];
    end
    case (s1_cmd_q)
      CMD_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          opb[i] = s1_s_q;
        end
      end
      CMD_DOT: begin
        for (int i = 0; i < 3; i++) begin
          opb[i] = s1_b_q[i];
        end
      end
      CMD_CROSS: begin
        opa[0] = s1_a_q[1]; opb[0] = s1_b_q[2];
        opa[1] = s1_a_q[2]; opb[1] = s1_b_q[0];
        opa[2] = s1_a_q[0]; opb[2] = s1_b_q[1];
        opa[3] = s1_a_q[2]; opb[3] = s1_b_q[1];
        opa[4] = s1_a_q[0]; opb[4] = s1_b_q[2];
        opa[5] = s1_a_q[1]; opb[5] = s1_b_q[0];
      end
      default: ;
    endcase
  end

  always_comb begin
    logic signed [32:0] sum;
    sat_t               st;
    s2_it_d     = '0;
    s2_it_d.cmd = s1_cmd_q;
    for (int i = 0; i < 3; i++) begin
      s2_it_d.neg[i] = s1_a_q[i][31];
      s2_it_d.x[i]   = s1_a_q[i][31] ? 32'(-s1_a_q[i]) : s1_a_q[i];
      // element selects are unsigned, so sign-extend explicitly
      if (s1_cmd_q == CMD_SUB) sum = 33'($signed(s1_a_q[i])) - 33'($signed(s1_b_q[i]));
      else                     sum = 33'($signed(s1_a_q[i])) + 33'($signed(s1_b_q[i]));
      st = sat32(66'(sum));
      if (s1_cmd_q == CMD_ADD || s1_cmd_q == CMD_SUB) begin
        s2_it_d.r[i] = st.val;
        s2_it_d.ovf  = s2_it_d.ovf | st.ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else         s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 6; i++) begin
      s2_p_q[i] <= opa[i] * opb[i];
    end
    s2_it_q <= s2_it_d;
  end

  // ---------------- stage 3: sums of products
  logic                    s3_v_q;
  item_t                   s3_it_q;
  logic signed [65:0]      s3_d_q [3];
  logic signed [65:0]      s3_d_d [3];
  logic [63:0]             s3_sq_q;
  logic signed [65:0]      psum;

  assign psum = 66'(s2_p_q[0]) + 66'(s2_p_q[1]) + 66'(s2_p_q[2]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s2_it_q.cmd == CMD_CROSS) s3_d_d[i] = 66'(s2_p_q[i]) - 66'(s2_p_q[i + 3]);
      else                          s3_d_d[i] = 66'(s2_p_q[i]);
    end
    if (s2_it_q.cmd == CMD_DOT) s3_d_d[0] = psum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else         s3_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    s3_it_q <= s2_it_q;
    s3_d_q  <= s3_d_d;
    s3_sq_q <= psum[63:0];
  end

  // ---------------- stage 4: floor shift and saturate
  logic  s4_v_q;
  nrm_t  s4_d, s4_q;

  always_comb begin
    logic signed [65:0] sh;
    sat_t               st;
    s4_d.it = s3_it_q;
    s4_d.t  = s3_sq_q;
    for (int i = 0; i < 3; i++) begin
      sh = s3_d_q[i] >>> FRAC_BITS;
      st = sat32(sh);
      if (s3_it_q.cmd == CMD_SCALE || s3_it_q.cmd == CMD_CROSS) begin
        s4_d.it.r[i] = st.val;
        s4_d.it.ovf  = s4_d.it.ovf | st.ovf;
      end else if (s3_it_q.cmd == CMD_DOT && i == 0) begin
        s4_d.it.sc  = st.val;
        s4_d.it.ovf = s4_d.it.ovf | st.ovf;
      end
    end
    s4_d.it.zl = (s3_it_q.cmd == CMD_NORM) && (s3_sq_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else         s4_v_q <= s3_v_q;
  end

  always_ff @(posedge clk_i) begin
    s4_q <= s4_d;
  end

  // ---------------- normalising shift: even leading zeros, 32/16/8/4/2 bits
  logic [N_NORM-1:0] nrm_v_q;
  nrm_t              nrm_q [N_NORM];

  for (genvar k = 0; k < N_NORM; k++) begin : g_nrm
    localparam int unsigned SH = 32 >> k;
    nrm_t in, d;
    logic in_v;
    if (k == 0) begin : g_first
      assign in   = s4_q;
      assign in_v = s4_v_q;
    end else begin : g_next
      assign in   = nrm_q[k-1];
      assign in_v = nrm_v_q[k-1];
    end

    always_comb begin
      d = in;
      if (in.it.cmd == CMD_NORM && in.t[63 -: SH] == '0) begin
        d.t = in.t << SH;
        for (int i = 0; i < 3; i++) begin
          d.it.x[i] = in.it.x[i] << (SH / 2);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) nrm_v_q[k] <= 1'b0;
      else         nrm_v_q[k] <= in_v;
    end

    always_ff @(posedge clk_i) begin
      nrm_q[k] <= d;
    end
  end

  // ---------------- square root, one result bit per stage
  logic [N_SQRT-1:0] sqr_v_q;
  sqr_t              sqr_q [N_SQRT];

  for (genvar k = 0; k < N_SQRT; k++) begin : g_sqr
    localparam logic [63:0] SQ_BIT = 64'd1 << (2 * N_SQRT - 2 - 2 * k);
    sqr_t in, d;
    logic in_v;
    logic [63:0] trial;
    if (k == 0) begin : g_first
      assign in.it  = nrm_q[N_NORM-1].it;
      assign in.n   = nrm_q[N_NORM-1].t;
      assign in.res = '0;
      assign in_v   = nrm_v_q[N_NORM-1];
    end else begin : g_next
      assign in   = sqr_q[k-1];
      assign in_v = sqr_v_q[k-1];
    end

    assign trial = in.res + SQ_BIT;

    always_comb begin
      d = in;
      if (in.n >= trial) begin
        d.n   = in.n - trial;
        d.res = (in.res >> 1) + SQ_BIT;
      end else begin
        d.res = in.res >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sqr_v_q[k] <= 1'b0;
      else         sqr_v_q[k] <= in_v;
    end

    always_ff @(posedge clk_i) begin
      sqr_q[k] <= d;
    end
  end

  // ---------------- restoring divide (x << FRAC_BITS) / m, three lanes
  logic [N_DIV-1:0] div_v_q;
  div_t             div_q [N_DIV];

  for (genvar k = 0; k < N_DIV; k++) begin : g_div
    div_t in, d;
    logic in_v;
    logic [2:0][32:0] tr;
    if (k == 0) begin : g_first
      assign in.it  = sqr_q[N_SQRT-1].it;
      assign in.m   = sqr_q[N_SQRT-1].res[31:0];
      assign in.rem = '0;
      assign in.q   = '0;
      assign in_v   = sqr_v_q[N_SQRT-1];
      for (genvar i = 0; i < 3; i++) begin : g_tr
        assign tr[i] = {1'b0, in.it.x[i]};
      end
    end else begin : g_next
      assign in   = div_q[k-1];
      assign in_v = div_v_q[k-1];
      for (genvar i = 0; i < 3; i++) begin : g_tr
        assign tr[i] = {in.rem[i], 1'b0};
      end
    end

    always_comb begin
      d = in;
      for (int i = 0; i < 3; i++) begin
        if (tr[i] >= {1'b0, in.m}) begin
          d.rem[i] = 32'(tr[i] - {1'b0, in.m});
          d.q[i]   = {in.q[i][QW-2:0], 1'b1};
        end else begin
          d.rem[i] = tr[i][31:0];
          d.q[i]   = {in.q[i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) div_v_q[k] <= 1'b0;
      else         div_v_q[k] <= in_v;
    end

    always_ff @(posedge clk_i) begin
      div_q[k] <= d;
    end
  end

  // ---------------- output register
  div_t             fin;
  logic             done_q;
  logic [2:0][31:0] r_d, r_q;
  logic [31:0]      sc_d, sc_q;
  logic             zl_d, zl_q, ovf_d, ovf_q;

  assign fin = div_q[N_DIV-1];

  always_comb begin
    logic [31:0] qx;
    r_d   = fin.it.r;
    sc_d  = fin.it.sc;
    zl_d  = fin.it.zl;
    ovf_d = fin.it.ovf;
    case (fin.it.cmd)
      CMD_MAG: begin
        sc_d  = fin.m[31] ? MAX32 : fin.m;
        ovf_d = fin.m[31];
      end
      CMD_NORM: begin
        for (int i = 0; i < 3; i++) begin
          qx     = {{(32 - QW){1'b0}}, fin.q[i]};
          r_d[i] = fin.it.zl ? '0 : (fin.it.neg[i] ? 32'd0 - qx : qx);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= div_v_q[N_DIV-1];
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    sc_q  <= sc_d;
    zl_q  <= zl_d;
    ovf_q <= ovf_d;
  end

  assign done_o        = done_q;
  assign r_x_o         = r_q[0];
  assign r_y_o         = r_q[1];
  assign r_z_o         = r_q[2];
  assign scalar_out_o  = sc_q;
  assign zero_length_o = zl_q;
  assign overflow_o    = ovf_q;

  // ---------------- checks
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LATENCY done_o)
    else $error("word lost in pipeline");

  a_no_phantom : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LATENCY))
    else $error("result without a matching start");

  a_zero_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && zero_length_o |->
      r_x_o == '0 && r_y_o == '0 && r_z_o == '0 && !overflow_o)
    else $error("zero-length normalise gave non-zero result");

endmodule

`default_nettype wire
